### rtl/nibble_framebuffer_line_raster_core_assert.svh
// Assertion macros for the nibble framebuffer line engine.
// Used by the port checker; needs nothing else.
`ifndef NIBBLE_FRAMEBUFFER_LINE_RASTER_CORE_ASSERT_SVH
`define NIBBLE_FRAMEBUFFER_LINE_RASTER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define NFB_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line engine check failed");

// next-cycle implication, disabled in reset
`define NFB_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line engine check failed");

`endif

### rtl/nfb_pkg.sv
// Shared types, widths and codes of the nibble framebuffer line engine.
// No dependencies.
package nfb_pkg;

   localparam int MAX_DIM    = 1024;
   localparam int FRAC_BITS  = 15;
   localparam int COORD_W    = $clog2(MAX_DIM);
   localparam int SLOPE_W    = FRAC_BITS + 1;
   localparam int CNT_W      = COORD_W + 1;
   localparam int DIM_W      = COORD_W + 1;
   localparam int ROW_W      = 10;
   localparam int ADDR_W     = 19;
   localparam int PEN_W      = 4;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int DIV_CNT_W  = $clog2(SLOPE_W);

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd2;

   // register reset values
   localparam logic [ROW_W-1:0] ROW_BYTES_RST     = 10'd160;
   localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 11'd320;
   localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 11'd240;

   typedef struct packed {
      logic               cmd;
      logic [COORD_W-1:0] x_start;
      logic [COORD_W-1:0] y_start;
      logic [COORD_W-1:0] x_end;
      logic [COORD_W-1:0] y_end;
      logic [PEN_W-1:0]   pen;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] write_address;
      logic              high_nibble;
      logic [PEN_W-1:0]  pixel_value;
      logic              last;
   } rsp_type;

   // decoded start command
   typedef struct packed {
      logic               ok;
      logic               span;
      logic [COORD_W-1:0] cur_x;
      logic [COORD_W-1:0] cur_y;
      logic [CNT_W-1:0]   pixels_left;
      logic               x_major;
      logic               y_down;
      logic [COORD_W-1:0] minor;
      logic [COORD_W-1:0] major;
   } setup_type;

   // divider launch
   typedef struct packed {
      logic               start;
      logic [COORD_W-1:0] num;
      logic [COORD_W-1:0] den;
   } div_req_type;

endpackage

### rtl/nfb_setup.sv
// Start command decode: endpoint bounds check, span detection, swap to rising x.
// Depends on nfb_pkg.
module nfb_setup
   import nfb_pkg::*;
(
   input  req_type            cmd_in,
   input  logic [DIM_W-1:0]   screen_width,
   input  logic [DIM_W-1:0]   screen_height,
   output setup_type          setup
);

   logic [COORD_W-1:0] adx;
   logic [COORD_W-1:0] ady;
   logic               swap;
   logic [COORD_W-1:0] x0;
   logic [COORD_W-1:0] y0;
   logic [COORD_W-1:0] y1;
   logic               x_dom;

   // absolute deltas and endpoint order
   assign adx   = (cmd_in.x_start > cmd_in.x_end) ? cmd_in.x_start - cmd_in.x_end
                                                  : cmd_in.x_end - cmd_in.x_start;
   assign ady   = (cmd_in.y_start > cmd_in.y_end) ? cmd_in.y_start - cmd_in.y_end
                                                  : cmd_in.y_end - cmd_in.y_start;
   assign swap  = cmd_in.x_end < cmd_in.x_start;
   assign x0    = swap ? cmd_in.x_end   : cmd_in.x_start;
   assign y0    = swap ? cmd_in.y_end   : cmd_in.y_start;
   assign y1    = swap ? cmd_in.y_start : cmd_in.y_end;
   assign x_dom = adx > ady;

   // pick span or slope walk
   always_comb begin
      setup.ok = ({1'b0, cmd_in.x_start} < screen_width)
              && ({1'b0, cmd_in.x_end}   < screen_width)
              && ({1'b0, cmd_in.y_start} < screen_height)
              && ({1'b0, cmd_in.y_end}   < screen_height);
      setup.minor = x_dom ? ady : adx;
      setup.major = x_dom ? adx : ady;
      if (cmd_in.y_start == cmd_in.y_end) begin
         setup.span        = 1'b1;
         setup.cur_x       = x0;
         setup.cur_y       = cmd_in.y_start;
         setup.pixels_left = {1'b0, adx} + CNT_W'(1);
         setup.x_major     = 1'b1;
         setup.y_down      = 1'b1;
      end else if (cmd_in.x_start == cmd_in.x_end) begin
         setup.span        = 1'b1;
         setup.cur_x       = cmd_in.x_start;
         setup.cur_y       = (cmd_in.y_start < cmd_in.y_end) ? cmd_in.y_start : cmd_in.y_end;
         setup.pixels_left = {1'b0, ady} + CNT_W'(1);
         setup.x_major     = 1'b0;
         setup.y_down      = 1'b1;
      end else begin
         setup.span        = 1'b0;
         setup.cur_x       = x0;
         setup.cur_y       = y0;
         setup.pixels_left = {1'b0, (x_dom ? adx : ady)};
         setup.x_major     = x_dom;
         setup.y_down      = y1 > y0;
      end
   end

endmodule

### rtl/nfb_div.sv
// Restoring divider for the line slope: (num << FRAC_BITS) / den, one quotient bit a cycle.
// Depends on nfb_pkg; expects num <= den and den nonzero.
module nfb_div
   import nfb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_req_type         div_req,
   output logic                div_done,
   output logic [SLOPE_W-1:0]  quotient
);

   logic                 run_ff,  run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff,  cnt_in;
   logic [COORD_W-1:0]   rem_ff,  rem_in;
   logic [COORD_W-1:0]   den_ff,  den_in;
   logic [SLOPE_W-1:0]   lo_ff,   lo_in;
   logic [SLOPE_W-1:0]   quo_ff,  quo_in;
   logic [COORD_W:0]     shifted;
   logic [COORD_W:0]     trial;
   logic                 fits;

   // shared subtract and compare
   assign shifted = {rem_ff, lo_ff[SLOPE_W-1]};
   assign trial   = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   // sequence the quotient bits
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      lo_in   = lo_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = div_req.num >> 1;
         den_in = div_req.den;
         lo_in  = {div_req.num[0], {FRAC_BITS{1'b0}}};
         quo_in = '0;
      end else if (run_ff) begin
         rem_in = fits ? trial[COORD_W-1:0] : shifted[COORD_W-1:0];
         lo_in  = {lo_ff[SLOPE_W-2:0], 1'b0};
         quo_in = {quo_ff[SLOPE_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(SLOPE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/nibble_framebuffer_line_raster_core.sv
// Line engine for a 4-bit-per-pixel framebuffer: sequencer, DDA walker, output register.
// Depends on nfb_pkg, nfb_setup and nfb_div.
//
// Usage:
//  - req channel carries commands: cmd start latches endpoints and pen, cmd tick asks
//    for the next pixel write of the current line.
//  - rsp channel carries one beat per tick while a line is active: byte address
//    y*row_bytes + x/2, nibble select (odd x is high), pen and a last flag.
//  - csr port writes row_bytes, screen_width and screen_height; write only while idle.
//  - A tick's beat appears in the output register the next cycle,
//    and ticks may follow every cycle while rsp is not stalled.
//  - A start of a sloped line waits for its slope: the slope comes from a
//    restoring divider that produces one quotient bit a cycle (FRAC_BITS + 1 bits)
//    and is then handed back to the sequencer; req_stall is high meanwhile.
//    Spans and rejected starts do not wait for the divider.
//  - A start with an endpoint outside the screen is dropped and leaves the line alone.
//  - Reset clears the line, the output valid flag and loads the register defaults.
//  - While rsp is stalled with a beat waiting, the beat holds and req_stall is high.
module nibble_framebuffer_line_raster_core
   import nfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;
   localparam logic [SLOPE_W-1:0] ONE_FIX = SLOPE_W'(1) << FRAC_BITS;

   logic                     state_ff,     state_in;
   logic                     busy_ff,      busy_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]         row_bytes_ff, row_bytes_in;
   logic [DIM_W-1:0]         width_ff,     width_in;
   logic [DIM_W-1:0]         height_ff,    height_in;
   logic [COORD_W-1:0]       cur_x_ff,     cur_x_in;
   logic [COORD_W-1:0]       cur_y_ff,     cur_y_in;
   logic [CNT_W-1:0]         left_ff,      left_in;
   logic [SLOPE_W-1:0]       acc_ff,       acc_in;
   logic [SLOPE_W-1:0]       slope_ff,     slope_in;
   logic                     x_major_ff,   x_major_in;
   logic                     y_down_ff,    y_down_in;
   logic [PEN_W-1:0]         pen_ff,       pen_in;
   rsp_type                  rsp_ff,       rsp_in;

   setup_type                setup;
   div_req_type              div_req;
   logic                     div_done;
   logic [SLOPE_W-1:0]       quotient;
   logic                     out_free;
   logic                     accept;
   logic                     start_go;
   logic                     tick_go;
   logic [COORD_W+ROW_W-1:0] row_off;
   logic [ADDR_W-1:0]        addr;
   logic [CNT_W-1:0]         left_dec;
   logic [SLOPE_W-1:0]       acc_sum;
   logic                     carry;

   function automatic logic [COORD_W-1:0] y_next(input logic [COORD_W-1:0] y,
                                                 input logic down);
      y_next = down ? y + COORD_W'(1) : y - COORD_W'(1);
   endfunction

   nfb_setup u_setup (
      .cmd_in        (req_payload),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .setup         (setup)
   );

   nfb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .quotient (quotient)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign start_go  = accept && (req_payload.cmd == CMD_START) && setup.ok;
   assign tick_go   = accept && (req_payload.cmd == CMD_TICK) && busy_ff;

   assign div_req.start = start_go && !setup.span;
   assign div_req.num   = setup.minor;
   assign div_req.den   = setup.major;

   // pixel address and DDA step
   assign row_off  = cur_y_ff * row_bytes_ff;
   assign addr     = row_off[ADDR_W-1:0] + ADDR_W'(cur_x_ff >> 1);
   assign left_dec = left_ff - CNT_W'(1);
   assign acc_sum  = acc_ff + slope_ff;
   assign carry    = acc_sum[FRAC_BITS];

   // next state
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      left_in      = left_ff;
      acc_in       = acc_ff;
      slope_in     = slope_ff;
      x_major_in   = x_major_ff;
      y_down_in    = y_down_ff;
      pen_in       = pen_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (start_go) begin
               busy_in    = 1'b1;
               cur_x_in   = setup.cur_x;
               cur_y_in   = setup.cur_y;
               left_in    = setup.pixels_left;
               x_major_in = setup.x_major;
               y_down_in  = setup.y_down;
               pen_in     = req_payload.pen;
               acc_in     = '0;
               slope_in   = '0;
               if (!setup.span) begin
                  state_in = ST_DIV;
               end
            end else if (tick_go) begin
               rsp_valid_in          = 1'b1;
               rsp_in.write_address  = addr;
               rsp_in.high_nibble    = cur_x_ff[0];
               rsp_in.pixel_value    = pen_ff;
               rsp_in.last           = (left_dec == '0);
               left_in               = left_dec;
               if (left_dec == '0) begin
                  busy_in = 1'b0;
               end
               // advance major axis, then minor on carry
               if (x_major_ff) begin
                  cur_x_in = cur_x_ff + COORD_W'(1);
                  cur_y_in = carry ? y_next(cur_y_ff, y_down_ff) : cur_y_ff;
               end else begin
                  cur_y_in = y_next(cur_y_ff, y_down_ff);
                  cur_x_in = carry ? cur_x_ff + COORD_W'(1) : cur_x_ff;
               end
               acc_in = carry ? acc_sum - ONE_FIX : acc_sum;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               slope_in = quotient;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      row_bytes_in = row_bytes_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_BYTES:     row_bytes_in = csr_write_data[ROW_W-1:0];
            CSR_SCREEN_WIDTH:  width_in     = csr_write_data[DIM_W-1:0];
            CSR_SCREEN_HEIGHT: height_in    = csr_write_data[DIM_W-1:0];
            default:           row_bytes_in = row_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_bytes_ff <= ROW_BYTES_RST;
         width_ff     <= SCREEN_WIDTH_RST;
         height_ff    <= SCREEN_HEIGHT_RST;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         row_bytes_ff <= row_bytes_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      left_ff    <= left_in;
      acc_ff     <= acc_in;
      slope_ff   <= slope_in;
      x_major_ff <= x_major_in;
      y_down_ff  <= y_down_in;
      pen_ff     <= pen_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/nfb_checker.sv
// Port-level checks for the line engine, bound to the top level.
// Depends on nfb_pkg and the assertion macro header.
`include "nibble_framebuffer_line_raster_core_assert.svh"

module nfb_checker
   import nfb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   logic rsp_held;
   logic start_take;
   logic tick_take;

   // accepted command beats and a waiting result beat
   assign rsp_held   = rsp_valid && rsp_stall;
   assign start_take = req_valid && !req_stall && (req_payload.cmd == CMD_START);
   assign tick_take  = req_valid && !req_stall && (req_payload.cmd == CMD_TICK);

   // hold a stalled result beat
   `NFB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // no result straight out of reset
   `NFB_ASSERT_IMP(a_rsp_reset, clock, reset, $past(reset), !rsp_valid)

   // a start beat never makes a result
   `NFB_ASSERT_NXT(a_start_quiet, clock, reset, start_take && !rsp_valid, !rsp_valid)

   // a new result follows an accepted tick
   `NFB_ASSERT_IMP(a_rsp_from_tick, clock, reset, $rose(rsp_valid), $past(tick_take))

endmodule

bind nibble_framebuffer_line_raster_core nfb_checker u_nfb_checker (.*);
